// ===== hw/rtl/rrp_pkg.sv =====
// Shared types, codes and helper functions for the relative rectangle converter.
package rrp_pkg;

  // Unit mode codes carried on the operation field.
  typedef enum logic [1:0] {
    MODE_PIX  = 2'd0,
    MODE_FRAC = 2'd1,
    MODE_TILE = 2'd2,
    MODE_BAD  = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SCENE_W  = 3'd0,
    REG_SCENE_H  = 3'd1,
    REG_TILE_W   = 3'd2,
    REG_TILE_H   = 3'd3,
    REG_ASPECT_W = 3'd4,
    REG_ASPECT_H = 3'd5
  } reg_index_t;

  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [15:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [15:0] PIX_MIN = 16'sh8000;

  // Clipped Q value with its overflow flag.
  typedef struct packed {
    logic              sat;
    logic signed [31:0] v;
  } clip_t;

  // Clipped pixel value with its overflow flag.
  typedef struct packed {
    logic              sat;
    logic signed [15:0] v;
  } pix_t;

  // Per-item fields that ride along the back half of the pipeline.
  typedef struct packed {
    logic               merr;
    logic               sat;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [50:0] xm;
    logic signed [50:0] ym;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic               fillw;
    logic               fillh;
  } carry_t;

  // Restoring divider state: partial remainder, shifting dividend/quotient word.
  typedef struct packed {
    logic [15:0] rem;
    logic [31:0] word;
    logic [15:0] dsr;
    logic        neg;
    logic        ovf;
  } div_t;

  // Clip a wide signed value to the signed 32-bit range.
  function automatic clip_t clip_q(input logic signed [65:0] v);
    clip_t c;
    c.sat = 1'b0;
    c.v   = v[31:0];
    if (v > 66'(Q_MAX)) begin
      c.sat = 1'b1;
      c.v   = Q_MAX;
    end else if (v < 66'(Q_MIN)) begin
      c.sat = 1'b1;
      c.v   = Q_MIN;
    end
    return c;
  endfunction

  // Round a Q value to whole pixels by floor(v + 1/2) and clip to 16 bits.
  function automatic pix_t pix_round(input logic signed [31:0] r, input int unsigned fb);
    logic signed [32:0] t;
    pix_t p;
    t = (33'(r) + (33'sd1 <<< (fb - 1))) >>> fb;
    p.sat = 1'b0;
    p.v   = t[15:0];
    if (t > 33'(PIX_MAX)) begin
      p.sat = 1'b1;
      p.v   = PIX_MAX;
    end else if (t < 33'(PIX_MIN)) begin
      p.sat = 1'b1;
      p.v   = PIX_MIN;
    end
    return p;
  endfunction

  // Four quotient bits of the restoring divider.
  function automatic div_t div_step4(input div_t d);
    div_t r;
    logic [16:0] t;
    r = d;
    for (int i = 0; i < 4; i++) begin
      t = {r.rem, r.word[31]};
      if (t >= {1'b0, r.dsr}) begin
        r.rem  = 16'(t - {1'b0, r.dsr});
        r.word = {r.word[30:0], 1'b1};
      end else begin
        r.rem  = t[15:0];
        r.word = {r.word[30:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/relative_rect_to_pixels_top.sv =====
// Top level: pipelined conversion of a relative rectangle to absolute pixels.
//
// Usage:
//   Input channel: an item is taken at a rising edge with start high and busy
//   low. busy is always low: the pipeline takes one item every cycle.
//   Output channel: done is high for one cycle with the result on abs_*,
//   pix_*, mode_error and saturated; the result is taken at the edge that
//   ends that cycle. The receiver cannot stall the block.
//   Configuration: cfg_we writes cfg_data into the register at cfg_addr at
//   the edge; write only while no item is in flight.
// Timing:
//   Throughput is one item per cycle. The depth is set by the ratio divider,
//   eight stages of four quotient bits each, plus the multiply, clip,
//   anchor and rounding stages around it.
// Reset:
//   rst clears all valid bits and loads the register defaults (scene 640 x
//   480, tile 1 x 1, no aspect ratio). Items in flight are dropped.
module relative_rect_to_pixels_top
  import rrp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic signed [31:0] rel_x,
  input  logic signed [31:0] rel_y,
  input  logic signed [31:0] rel_w,
  input  logic signed [31:0] rel_h,
  input  logic signed [31:0] anchor_x,
  input  logic signed [31:0] anchor_y,
  input  logic               has_base,
  input  logic signed [15:0] base_x,
  input  logic signed [15:0] base_y,
  input  logic [15:0]        base_w,
  input  logic [15:0]        base_h,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] abs_x,
  output logic signed [31:0] abs_y,
  output logic signed [31:0] abs_w,
  output logic signed [31:0] abs_h,
  output logic signed [15:0] pix_x,
  output logic signed [15:0] pix_y,
  output logic signed [15:0] pix_w,
  output logic signed [15:0] pix_h,
  output logic               mode_error,
  output logic               saturated
);

  localparam int unsigned      DIV_STAGES = 8;
  localparam logic signed [33:0] ONE_Q    = 34'(64'd1 << FRAC_BITS);

  // Configuration registers
  logic [15:0] scene_width, scene_height;
  logic [12:0] tile_width, tile_height;
  logic [15:0] aspect_width, aspect_height;

  // Write a configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scene_width   <= 16'd640;
      scene_height  <= 16'd480;
      tile_width    <= 13'd1;
      tile_height   <= 13'd1;
      aspect_width  <= 16'd0;
      aspect_height <= 16'd0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_SCENE_W:  scene_width   <= cfg_data;
        REG_SCENE_H:  scene_height  <= cfg_data;
        REG_TILE_W:   tile_width    <= cfg_data[12:0];
        REG_TILE_H:   tile_height   <= cfg_data[12:0];
        REG_ASPECT_W: aspect_width  <= cfg_data;
        REG_ASPECT_H: aspect_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage A: select base and scale factors
  mode_t              mode_in;
  logic [15:0]        fx_in, fy_in;
  logic signed [33:0] xin_in, yin_in;

  always_comb begin
    mode_in = mode_t'(operation);
    case (mode_in)
      MODE_PIX: begin
        fx_in = 16'd1;
        fy_in = 16'd1;
      end
      MODE_FRAC: begin
        fx_in = has_base ? base_w : scene_width;
        fy_in = has_base ? base_h : scene_height;
      end
      default: begin
        fx_in = {3'b0, tile_width};
        fy_in = {3'b0, tile_height};
      end
    endcase
    if (mode_in == MODE_TILE) begin
      xin_in = 34'(rel_x) - ONE_Q + 34'(anchor_x);
      yin_in = 34'(rel_y) - ONE_Q + 34'(anchor_y);
    end else begin
      xin_in = 34'(rel_x);
      yin_in = 34'(rel_y);
    end
  end

  logic               va;
  mode_t              a_mode;
  logic signed [31:0] a_rw, a_rh, a_ax, a_ay;
  logic signed [33:0] a_xin, a_yin;
  logic [15:0]        a_fx, a_fy;
  logic signed [15:0] a_px, a_py;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= accept;
    a_mode <= mode_in;
    a_rw   <= rel_w;
    a_rh   <= rel_h;
    a_ax   <= anchor_x;
    a_ay   <= anchor_y;
    a_xin  <= xin_in;
    a_yin  <= yin_in;
    a_fx   <= fx_in;
    a_fy   <= fy_in;
    a_px   <= has_base ? base_x : 16'sd0;
    a_py   <= has_base ? base_y : 16'sd0;
  end

  // Stage B: scale size and position
  logic               vb;
  mode_t              b_mode;
  logic signed [48:0] b_wm, b_hm;
  logic signed [50:0] b_xm, b_ym;
  logic signed [31:0] b_ax, b_ay;
  logic signed [15:0] b_px, b_py;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
    b_mode <= a_mode;
    b_wm   <= 49'(a_rw) * 49'($signed({1'b0, a_fx}));
    b_hm   <= 49'(a_rh) * 49'($signed({1'b0, a_fy}));
    b_xm   <= 51'(a_xin) * 51'($signed({1'b0, a_fx}));
    b_ym   <= 51'(a_yin) * 51'($signed({1'b0, a_fy}));
    b_ax   <= a_ax;
    b_ay   <= a_ay;
    b_px   <= a_px;
    b_py   <= a_py;
  end

  // Stage C: clip the scaled size
  clip_t  cw, ch;
  logic   vc;
  carry_t c_cr;

  assign cw = clip_q(66'(b_wm));
  assign ch = clip_q(66'(b_hm));

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else     vc <= vb;
    c_cr.merr  <= (b_mode == MODE_BAD);
    c_cr.sat   <= cw.sat | ch.sat;
    c_cr.px    <= b_px;
    c_cr.py    <= b_py;
    c_cr.ax    <= b_ax;
    c_cr.ay    <= b_ay;
    c_cr.xm    <= b_xm;
    c_cr.ym    <= b_ym;
    c_cr.w     <= cw.v;
    c_cr.h     <= ch.v;
    c_cr.fillw <= 1'b0;
    c_cr.fillh <= 1'b0;
  end

  // Stage D: decide the ratio fill and form the dividend
  logic               ratio_on, wz, hz, both, fill_w, fill_h, src_neg;
  logic signed [31:0] src;
  logic [31:0]        src_mag;
  clip_t              aw_q, ah_q;
  carry_t             d_cr_next;

  always_comb begin
    ratio_on = (aspect_width != 16'd0) && (aspect_height != 16'd0);
    wz       = (c_cr.w == 32'sd0);
    hz       = (c_cr.h == 32'sd0);
    both     = ratio_on && wz && hz;
    fill_w   = ratio_on && wz && !hz;
    fill_h   = ratio_on && hz && !wz;
    src      = fill_w ? c_cr.h : c_cr.w;
    src_neg  = src[31];
    src_mag  = src_neg ? 32'(-src) : 32'(src);
    aw_q     = clip_q($signed(66'(aspect_width) << FRAC_BITS));
    ah_q     = clip_q($signed(66'(aspect_height) << FRAC_BITS));
    d_cr_next       = c_cr;
    d_cr_next.fillw = fill_w;
    d_cr_next.fillh = fill_h;
    if (both) begin
      d_cr_next.w   = aw_q.v;
      d_cr_next.h   = ah_q.v;
      d_cr_next.sat = c_cr.sat | aw_q.sat | ah_q.sat;
    end
  end

  logic        vd;
  carry_t      d_cr;
  logic [47:0] d_num;
  logic [15:0] d_dsr;
  logic        d_neg;

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else     vd <= vc;
    d_cr  <= d_cr_next;
    d_num <= 48'(src_mag) * 48'(fill_w ? aspect_width : aspect_height);
    d_dsr <= fill_w ? aspect_height : aspect_width;
    d_neg <= src_neg;
  end

  // Stage E and divider stages: overflow check, then four quotient bits a stage
  logic   dvv [0:DIV_STAGES];
  div_t   dv  [0:DIV_STAGES];
  carry_t dcr [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) dvv[k] <= 1'b0;
    end else begin
      dvv[0] <= vd;
      for (int k = 1; k <= DIV_STAGES; k++) dvv[k] <= dvv[k-1];
    end
    dv[0].ovf  <= (d_num >= {d_dsr, 32'd0});
    dv[0].rem  <= d_num[47:32];
    dv[0].word <= d_num[31:0];
    dv[0].dsr  <= d_dsr;
    dv[0].neg  <= d_neg;
    dcr[0]     <= d_cr;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      dv[k]  <= div_step4(dv[k-1]);
      dcr[k] <= dcr[k-1];
    end
  end

  // Stage F: sign and clip the quotient, drop it into the missing dimension
  logic signed [65:0] q_s;
  clip_t              q_c;
  carry_t             f_cr_next;

  always_comb begin
    q_s = $signed(66'(dv[DIV_STAGES].word));
    if (dv[DIV_STAGES].neg) q_s = -q_s;
    q_c = clip_q(q_s);
    if (dv[DIV_STAGES].ovf) begin
      q_c.sat = 1'b1;
      q_c.v   = dv[DIV_STAGES].neg ? Q_MIN : Q_MAX;
    end
    f_cr_next = dcr[DIV_STAGES];
    if (dcr[DIV_STAGES].fillw) begin
      f_cr_next.w   = q_c.v;
      f_cr_next.sat = dcr[DIV_STAGES].sat | q_c.sat;
    end
    if (dcr[DIV_STAGES].fillh) begin
      f_cr_next.h   = q_c.v;
      f_cr_next.sat = dcr[DIV_STAGES].sat | q_c.sat;
    end
  end

  logic   vf;
  carry_t f_cr;

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else     vf <= dvv[DIV_STAGES];
    f_cr <= f_cr_next;
  end

  // Stage G: anchor products
  logic               vg;
  carry_t             g_cr;
  logic signed [63:0] g_ax_w, g_ay_h;

  always_ff @(posedge clk) begin
    if (rst) vg <= 1'b0;
    else     vg <= vf;
    g_cr   <= f_cr;
    g_ax_w <= 64'(f_cr.ax) * 64'(f_cr.w);
    g_ay_h <= 64'(f_cr.ay) * 64'(f_cr.h);
  end

  // Stage H: offset the position by origin and anchor, clip
  logic signed [65:0] xs, ys;
  clip_t              xc, yc;

  always_comb begin
    xs = ($signed(66'(g_cr.px)) <<< FRAC_BITS) + 66'(g_cr.xm)
         - (66'(g_ax_w) >>> FRAC_BITS);
    ys = ($signed(66'(g_cr.py)) <<< FRAC_BITS) + 66'(g_cr.ym)
         - (66'(g_ay_h) >>> FRAC_BITS);
    xc = clip_q(xs);
    yc = clip_q(ys);
  end

  logic               vh;
  logic               h_merr, h_sat;
  logic signed [31:0] h_x, h_y, h_w, h_h;

  always_ff @(posedge clk) begin
    if (rst) vh <= 1'b0;
    else     vh <= vg;
    h_merr <= g_cr.merr;
    h_sat  <= g_cr.sat | xc.sat | yc.sat;
    h_x    <= xc.v;
    h_y    <= yc.v;
    h_w    <= g_cr.w;
    h_h    <= g_cr.h;
  end

  // Stage I: round to pixels and register the result beat
  pix_t rx_p, ry_p, rw_p, rh_p;

  assign rx_p = pix_round(h_x, FRAC_BITS);
  assign ry_p = pix_round(h_y, FRAC_BITS);
  assign rw_p = pix_round(h_w, FRAC_BITS);
  assign rh_p = pix_round(h_h, FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vh;
    if (h_merr) begin
      abs_x      <= 32'sd0;
      abs_y      <= 32'sd0;
      abs_w      <= 32'sd0;
      abs_h      <= 32'sd0;
      pix_x      <= 16'sd0;
      pix_y      <= 16'sd0;
      pix_w      <= 16'sd0;
      pix_h      <= 16'sd0;
      mode_error <= 1'b1;
      saturated  <= 1'b0;
    end else begin
      abs_x      <= h_x;
      abs_y      <= h_y;
      abs_w      <= h_w;
      abs_h      <= h_h;
      pix_x      <= rx_p.v;
      pix_y      <= ry_p.v;
      pix_w      <= rw_p.v;
      pix_h      <= rh_p.v;
      mode_error <= 1'b0;
      saturated  <= h_sat | rx_p.sat | ry_p.sat | rw_p.sat | rh_p.sat;
    end
  end

endmodule

// ===== hw/rtl/rrp_checker.sv =====
// Port-level checks for the relative rectangle converter, bound to the top level.
module rrp_checker
  import rrp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         operation,
  input logic               done,
  input logic signed [31:0] abs_x,
  input logic signed [31:0] abs_w,
  input logic signed [15:0] pix_x,
  input logic signed [15:0] pix_w,
  input logic               mode_error,
  input logic               saturated
);

  localparam logic signed [32:0] HALF = 33'sd1 <<< (FRAC_BITS - 1);

  // A bad-mode beat comes back flagged after the full latency
  a_bad_mode_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation == MODE_BAD) |-> ##17 done && mode_error)
    else $error("bad mode beat not flagged at expected latency");

  // A good-mode beat comes back unflagged after the full latency
  a_good_mode_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation != MODE_BAD) |-> ##17 done && !mode_error)
    else $error("good mode beat missing or flagged at expected latency");

  // A flagged beat carries zeros and no saturation
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && mode_error |-> !saturated && abs_x == 32'sd0 && abs_w == 32'sd0
                            && pix_x == 16'sd0 && pix_w == 16'sd0)
    else $error("bad mode beat carries data");

  // Unsaturated pixels match the rounded Q values
  a_pix_round: assert property (@(posedge clk) disable iff (rst)
    done && !mode_error && !saturated |->
      pix_x == 16'((33'(abs_x) + HALF) >>> FRAC_BITS)
      && pix_w == 16'((33'(abs_w) + HALF) >>> FRAC_BITS))
    else $error("pixel rounding mismatch");

endmodule

bind relative_rect_to_pixels_top rrp_checker #(.FRAC_BITS(FRAC_BITS)) u_rrp_checker (.*);

// ===== dv/tb_relative_rect_to_pixels_top.sv =====
// Self-checking testbench for the relative rectangle to pixel converter.
`timescale 1ns / 100ps

module tb_relative_rect_to_pixels_top;
  import rrp_pkg::*;

  localparam int unsigned FB = 16;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam longint Q_ONE = 64'sd1 <<< FB;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] rx, ry, rw, rh, ax, ay;
    logic               hb;
    logic signed [15:0] bx, by;
    logic [15:0]        bw, bh;
  } rect_item_t;

  typedef struct {
    logic signed [31:0] x, y, w, h;
    logic signed [15:0] px, py, pw, ph;
    logic               merr, sat;
  } pixel_rect_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation = '0;
  logic signed [31:0] rel_x = '0, rel_y = '0, rel_w = '0, rel_h = '0;
  logic signed [31:0] anchor_x = '0, anchor_y = '0;
  logic               has_base = 1'b0;
  logic signed [15:0] base_x = '0, base_y = '0;
  logic [15:0]        base_w = 16'd1, base_h = 16'd1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_addr = '0;
  logic [15:0]        cfg_data = '0;
  logic               done;
  logic signed [31:0] abs_x, abs_y, abs_w, abs_h;
  logic signed [15:0] pix_x, pix_y, pix_w, pix_h;
  logic               mode_error, saturated;

  // Shadow registers of the block's configuration
  longint scene_w_q = 640, scene_h_q = 480, tile_w_q = 1, tile_h_q = 1;
  longint aspect_w_q = 0, aspect_h_q = 0;

  pixel_rect_t expected_rects[$];
  int          error_count = 0;
  int          sender_idle_pct = 0;

  relative_rect_to_pixels_top #(.FRAC_BITS(FB)) i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint clamp(longint v, longint lo, longint hi, inout bit flag);
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Compute the absolute rectangle for one item under the current settings
  function automatic pixel_rect_t convert_rect(rect_item_t it);
    pixel_rect_t e;
    longint qmin, qmax, px, py, dw, dh, w, h, x, y, rx, ry, ax, ay;
    longint r[4];
    longint p[4];
    bit sat;
    qmin = longint'(Q_MIN);
    qmax = longint'(Q_MAX);
    px = 0;
    py = 0;
    sat = 1'b0;
    e = '{x: 0, y: 0, w: 0, h: 0, px: 0, py: 0, pw: 0, ph: 0, merr: 0, sat: 0};
    if (mode_t'(it.op) == MODE_BAD) begin
      e.merr = 1'b1;
      return e;
    end
    rx = longint'(it.rx);
    ry = longint'(it.ry);
    ax = longint'(it.ax);
    ay = longint'(it.ay);
    if (it.hb) begin
      px = longint'(it.bx) * Q_ONE;
      py = longint'(it.by) * Q_ONE;
      dw = longint'(it.bw);
      dh = longint'(it.bh);
    end else begin
      dw = scene_w_q;
      dh = scene_h_q;
    end
    case (mode_t'(it.op))
      MODE_PIX: begin
        w = longint'(it.rw);
        h = longint'(it.rh);
      end
      MODE_FRAC: begin
        w = longint'(it.rw) * dw;
        h = longint'(it.rh) * dh;
      end
      default: begin
        w = longint'(it.rw) * tile_w_q;
        h = longint'(it.rh) * tile_h_q;
      end
    endcase
    w = clamp(w, qmin, qmax, sat);
    h = clamp(h, qmin, qmax, sat);
    // Fill a zero size from the aspect ratio
    if (aspect_w_q != 0 && aspect_h_q != 0 && (w == 0 || h == 0)) begin
      if (w == 0 && h == 0) begin
        w = aspect_w_q * Q_ONE;
        h = aspect_h_q * Q_ONE;
      end else if (w == 0) begin
        w = (h * aspect_w_q) / aspect_h_q;
      end else begin
        h = (w * aspect_h_q) / aspect_w_q;
      end
      w = clamp(w, qmin, qmax, sat);
      h = clamp(h, qmin, qmax, sat);
    end
    case (mode_t'(it.op))
      MODE_PIX: begin
        x = px + rx - ((ax * w) >>> FB);
        y = py + ry - ((ay * h) >>> FB);
      end
      MODE_FRAC: begin
        x = px + rx * dw - ((ax * w) >>> FB);
        y = py + ry * dh - ((ay * h) >>> FB);
      end
      default: begin
        x = px + (rx - Q_ONE + ax) * tile_w_q - ((ax * w) >>> FB);
        y = py + (ry - Q_ONE + ay) * tile_h_q - ((ay * h) >>> FB);
      end
    endcase
    x = clamp(x, qmin, qmax, sat);
    y = clamp(y, qmin, qmax, sat);
    r[0] = x;
    r[1] = y;
    r[2] = w;
    r[3] = h;
    // Round half up to whole pixels
    for (int i = 0; i < 4; i++) begin
      p[i] = clamp((r[i] + (Q_ONE >>> 1)) >>> FB, -32768, 32767, sat);
    end
    e.x = r[0][31:0];
    e.y = r[1][31:0];
    e.w = r[2][31:0];
    e.h = r[3][31:0];
    e.px = p[0][15:0];
    e.py = p[1][15:0];
    e.pw = p[2][15:0];
    e.ph = p[3][15:0];
    e.sat = sat;
    return e;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Capture accepted beats and writes, check each result against the oldest expectation
  always @(posedge clk) begin
    pixel_rect_t e;
    rect_item_t it;
    if (!rst) begin
      if (done) begin
        if (expected_rects.size() == 0) begin
          $display("%0t: result with no expectation waiting", $time);
          error_count++;
        end else begin
          e = expected_rects.pop_front();
          check_field("abs_x", e.x, abs_x);
          check_field("abs_y", e.y, abs_y);
          check_field("abs_w", e.w, abs_w);
          check_field("abs_h", e.h, abs_h);
          check_field("pix_x", 32'(e.px), 32'(pix_x));
          check_field("pix_y", 32'(e.py), 32'(pix_y));
          check_field("pix_w", 32'(e.pw), 32'(pix_w));
          check_field("pix_h", 32'(e.ph), 32'(pix_h));
          check_field("mode_error", 32'(e.merr), 32'(mode_error));
          check_field("saturated", 32'(e.sat), 32'(saturated));
        end
      end
      if (start && !busy) begin
        it = '{op: operation, rx: rel_x, ry: rel_y, rw: rel_w, rh: rel_h,
               ax: anchor_x, ay: anchor_y, hb: has_base, bx: base_x, by: base_y,
               bw: base_w, bh: base_h};
        expected_rects.push_back(convert_rect(it));
      end
      if (cfg_we) begin
        case (reg_index_t'(cfg_addr))
          REG_SCENE_W:  scene_w_q = longint'(cfg_data);
          REG_SCENE_H:  scene_h_q = longint'(cfg_data);
          REG_TILE_W:   tile_w_q = longint'(cfg_data[12:0]);
          REG_TILE_H:   tile_h_q = longint'(cfg_data[12:0]);
          REG_ASPECT_W: aspect_w_q = longint'(cfg_data);
          REG_ASPECT_H: aspect_h_q = longint'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // Drive one beat, with random idle cycles ahead of it
  task automatic send_rect(rect_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    operation <= it.op;
    rel_x <= it.rx;
    rel_y <= it.ry;
    rel_w <= it.rw;
    rel_h <= it.rh;
    anchor_x <= it.ax;
    anchor_y <= it.ay;
    has_base <= it.hb;
    base_x <= it.bx;
    base_y <= it.by;
    base_w <= it.bw;
    base_h <= it.bh;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Drain the pipeline so a register write finds it empty
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(logic [15:0] sw, logic [15:0] sh, logic [15:0] tw,
                               logic [15:0] th, logic [15:0] aw, logic [15:0] ah);
    wait_drained();
    write_reg(REG_SCENE_W, sw);
    write_reg(REG_SCENE_H, sh);
    write_reg(REG_TILE_W, tw);
    write_reg(REG_TILE_H, th);
    write_reg(REG_ASPECT_W, aw);
    write_reg(REG_ASPECT_H, ah);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(7))
      0: return $urandom;
      1: return '0;
      2: return 32'($urandom_range(0, 1 << 18)) - 32'sd131072;
      3: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: return 32'($urandom_range(0, 1 << 26)) - 32'sd33554432;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_anchor();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'sd32768;
      2: return 32'sd65536;
      3: return $urandom;
      default: return 32'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [15:0] rand_base_size();
    return $urandom_range(0, 3) == 0 ? 16'($urandom_range(1, 65535))
                                     : 16'($urandom_range(1, 1024));
  endfunction

  function automatic rect_item_t rand_rect();
    rect_item_t it;
    it.op = ($urandom_range(9) == 0) ? MODE_BAD : 2'($urandom_range(0, 2));
    it.rx = rand_q();
    it.ry = rand_q();
    it.rw = rand_q();
    it.rh = rand_q();
    // Zero sizes often, to exercise the ratio fill
    case ($urandom_range(5))
      0: it.rw = '0;
      1: it.rh = '0;
      2: begin
        it.rw = '0;
        it.rh = '0;
      end
      default: ;
    endcase
    it.ax = rand_anchor();
    it.ay = rand_anchor();
    it.hb = 1'($urandom_range(0, 1));
    it.bx = 16'($urandom);
    it.by = 16'($urandom);
    it.bw = rand_base_size();
    it.bh = rand_base_size();
    return it;
  endfunction

  function automatic rect_item_t make_rect(mode_t op, logic signed [31:0] rx,
      logic signed [31:0] ry, logic signed [31:0] rw, logic signed [31:0] rh,
      logic signed [31:0] ax, logic signed [31:0] ay, logic hb);
    rect_item_t it;
    it = '{op: op, rx: rx, ry: ry, rw: rw, rh: rh, ax: ax, ay: ay, hb: hb,
           bx: 16'sh8000, by: 16'sh7FFF, bw: 16'hFFFF, bh: 16'd1};
    return it;
  endfunction

  // Each mode and field extremes with reset settings, so no ratio
  task automatic test_modes_and_extremes();
    send_rect(make_rect(MODE_PIX, 32'sd65536, 32'sd131072, 32'sd655360, 32'sd327680,
                        32'sd0, 32'sd0, 1'b0));
    send_rect(make_rect(MODE_FRAC, 32'sd32768, 32'sd16384, 32'sd32768, 32'sd65536,
                        32'sd32768, 32'sd65536, 1'b0));
    send_rect(make_rect(MODE_TILE, 32'sd65536, 32'sd196608, 32'sd131072, 32'sd65536,
                        32'sd32768, 32'sd32768, 1'b0));
    send_rect(make_rect(MODE_BAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    send_rect(make_rect(MODE_PIX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1));
    send_rect(make_rect(MODE_FRAC, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, 1'b1));
    send_rect(make_rect(MODE_TILE, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    send_rect(make_rect(MODE_PIX, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0));
    send_rect(make_rect(MODE_FRAC, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0,
                        32'sd65536, 1'b1));
    send_rect(make_rect(MODE_PIX, -32'sd32768, 32'sd32767, 32'sd98304, -32'sd98304,
                        -32'sd65536, 32'sd65536, 1'b0));
    send_rect(make_rect(MODE_PIX, 32'sh7FFF_8000, 32'sh8000_0000, 32'sd1, -32'sd1,
                        32'sd0, 32'sd0, 1'b0));
  endtask

  // Ratio fill of one zero size, both zero, and overflow of the fill
  task automatic test_ratio_fill();
    load_settings(16'd640, 16'd480, 16'd16, 16'd16, 16'd16, 16'd9);
    send_rect(make_rect(MODE_PIX, 32'sd0, 32'sd0, 32'sd0, 32'sd589824, 32'sd32768,
                        32'sd32768, 1'b0));
    send_rect(make_rect(MODE_PIX, 32'sd0, 32'sd0, 32'sd1048576, 32'sd0, 32'sd65536,
                        32'sd0, 1'b0));
    send_rect(make_rect(MODE_FRAC, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd32768,
                        32'sd32768, 1'b0));
    send_rect(make_rect(MODE_TILE, 32'sd65536, 32'sd65536, 32'sd0, -32'sd65536,
                        32'sd0, 32'sd0, 1'b0));
    load_settings(16'd640, 16'd480, 16'd16, 16'd16, 16'd65535, 16'd1);
    send_rect(make_rect(MODE_PIX, 32'sd0, 32'sd0, 32'sd0, Q_MAX, 32'sd0, 32'sd0, 1'b0));
    send_rect(make_rect(MODE_PIX, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0));
    send_rect(make_rect(MODE_PIX, 32'sd0, 32'sd0, Q_MIN, 32'sd0, 32'sd0, 32'sd0, 1'b0));
  endtask

  // Random beats across register settings and idle patterns
  task automatic test_random_settings();
    int idle_pcts[3] = '{0, 81, 13};
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_settings(16'd640, 16'd480, 16'd1, 16'd1, 16'd0, 16'd0);
        1: load_settings(16'd1, 16'd1, 16'd4096, 16'd4096, 16'd16, 16'd9);
        2: load_settings(16'd65535, 16'd65535, 16'd1, 16'd4096, 16'd65535, 16'd1);
        3: load_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                         16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
                         16'd1, 16'd65535);
        4: load_settings(16'd320, 16'd200, 16'd8, 16'd8, 16'd4, 16'd3);
        default: load_settings(16'($urandom_range(1, 65535)),
                               16'($urandom_range(1, 65535)),
                               16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
                               16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)));
      endcase
      sender_idle_pct = idle_pcts[ph % 3];
      repeat (120) send_rect(rand_rect());
      sender_idle_pct = 0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_modes_and_extremes();
    test_ratio_fill();
    test_random_settings();
    wait_drained();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
